### src/blpw_pkg.sv
// shared types and constants for the bresenham line pixel writer
`default_nettype none
package blpw_pkg;

    localparam int DIM_W     = 13;   // width of the image size registers
    localparam int ADDR_W    = 26;   // byte address width
    localparam int ROW_W     = 16;   // padded row size in bytes
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;
    localparam logic [ROW_W-1:0]  ROW_ROUND = 16'd3;
    localparam logic [ROW_W-1:0]  ROW_MASK  = ~16'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             mode;
    } t_cfg;

    typedef struct packed {
        logic color;
        logic last;
        logic error;
    } t_pix_flags;

endpackage
`default_nettype wire

### src/blpw_cfg.sv
// configuration registers: image width, image height and pixel mode
`default_nettype none
module blpw_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_we,
    input  wire logic [blpw_pkg::CFG_IDX_W-1:0] i_index,
    input  wire logic [blpw_pkg::DIM_W-1:0]     i_data,
    output blpw_pkg::t_cfg                      o_cfg
);

    blpw_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= blpw_pkg::DIM_W'(1);
            r_cfg.height <= blpw_pkg::DIM_W'(1);
            r_cfg.mode   <= 1'b0;
        end else if (i_we) begin
            case (i_index)
                blpw_pkg::CFG_WIDTH:  r_cfg.width  <= i_data;
                blpw_pkg::CFG_HEIGHT: r_cfg.height <= i_data;
                blpw_pkg::CFG_MODE:   r_cfg.mode   <= i_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### src/blpw_walk.sv
// input stage: bounds check, line set-up and one bresenham error step per transaction
`default_nettype none
module blpw_walk #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_opcode,
    input  wire logic [COORD_BITS-1:0] i_start_x,
    input  wire logic [COORD_BITS-1:0] i_start_y,
    input  wire logic [COORD_BITS-1:0] i_end_x,
    input  wire logic [COORD_BITS-1:0] i_end_y,
    input  wire logic                  i_color,
    input  wire blpw_pkg::t_cfg        i_cfg,
    input  wire logic                  i_ready,
    output logic                       o_pix_valid,
    output logic [COORD_BITS-1:0]      o_pix_x,
    output logic [COORD_BITS-1:0]      o_pix_y,
    output blpw_pkg::t_pix_flags       o_pix_flags
);

    localparam int CW = (COORD_BITS > blpw_pkg::DIM_W) ? COORD_BITS : blpw_pkg::DIM_W;
    localparam int DW = COORD_BITS + 1;   // signed deltas
    localparam int EW = COORD_BITS + 2;   // error term
    localparam int XW = COORD_BITS + 3;   // doubled error term

    // walk state
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic signed [DW-1:0]  r_dx, r_dyn;
    logic signed [EW-1:0]  r_err;
    logic                  r_sx_neg, r_sy_neg, r_active, r_color;

    // pixel stage register
    logic                  r_s1_valid;
    logic [COORD_BITS-1:0] r_s1_x, r_s1_y;
    blpw_pkg::t_pix_flags  r_s1_flags;

    logic                  accept, is_start, outside, same_pt;
    logic [COORD_BITS-1:0] adx, ady;
    logic signed [DW-1:0]  n_dx, n_dyn;
    logic signed [XW-1:0]  e2;
    logic                  mv_x, mv_y, done;
    logic signed [EW-1:0]  n_err;
    logic [COORD_BITS-1:0] n_x, n_y;

    assign o_stall  = r_s1_valid && !i_ready;
    assign accept   = i_valid && !o_stall;
    assign is_start = (i_opcode == blpw_pkg::OP_START);

    assign outside = (CW'(i_start_x) >= CW'(i_cfg.width))  ||
                     (CW'(i_end_x)   >= CW'(i_cfg.width))  ||
                     (CW'(i_start_y) >= CW'(i_cfg.height)) ||
                     (CW'(i_end_y)   >= CW'(i_cfg.height));

    assign adx     = (i_end_x > i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign ady     = (i_end_y > i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);
    assign n_dx    = $signed({1'b0, adx});
    assign n_dyn   = -$signed({1'b0, ady});
    assign same_pt = (i_start_x == i_end_x) && (i_start_y == i_end_y);

    // one error step
    assign e2    = XW'(r_err) <<< 1;
    assign mv_x  = (e2 >= XW'(r_dyn));
    assign mv_y  = (e2 <= XW'(r_dx));
    assign n_err = r_err + (mv_x ? EW'(r_dyn) : EW'(0)) + (mv_y ? EW'(r_dx) : EW'(0));
    assign n_x   = mv_x ? (r_sx_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1) : r_cur_x;
    assign n_y   = mv_y ? (r_sy_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1) : r_cur_y;
    assign done  = (n_x == r_tgt_x) && (n_y == r_tgt_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_tgt_x    <= '0;
            r_tgt_y    <= '0;
            r_dx       <= '0;
            r_dyn      <= '0;
            r_err      <= '0;
            r_sx_neg   <= 1'b0;
            r_sy_neg   <= 1'b0;
            r_active   <= 1'b0;
            r_color    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_s1_valid <= accept && (is_start || r_active);
            end
            if (accept) begin
                if (is_start) begin
                    r_active <= 1'b0;
                    if (!outside) begin
                        r_cur_x  <= i_start_x;
                        r_cur_y  <= i_start_y;
                        r_tgt_x  <= i_end_x;
                        r_tgt_y  <= i_end_y;
                        r_dx     <= n_dx;
                        r_dyn    <= n_dyn;
                        r_sx_neg <= !(i_start_x < i_end_x);
                        r_sy_neg <= !(i_start_y < i_end_y);
                        r_err    <= EW'(n_dx) + EW'(n_dyn);
                        r_color  <= i_color;
                        r_active <= !same_pt;
                    end
                end else if (r_active) begin
                    r_cur_x <= n_x;
                    r_cur_y <= n_y;
                    r_err   <= n_err;
                    if (done) begin
                        r_active <= 1'b0;
                    end
                end
            end
        end
    end

    // payload of the pixel stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (is_start) begin
                r_s1_x           <= i_start_x;
                r_s1_y           <= i_start_y;
                r_s1_flags.color <= i_color;
                r_s1_flags.last  <= same_pt;
                r_s1_flags.error <= outside;
            end else begin
                r_s1_x           <= n_x;
                r_s1_y           <= n_y;
                r_s1_flags.color <= r_color;
                r_s1_flags.last  <= done;
                r_s1_flags.error <= 1'b0;
            end
        end
    end

    assign o_pix_valid = r_s1_valid;
    assign o_pix_x     = r_s1_x;
    assign o_pix_y     = r_s1_y;
    assign o_pix_flags = r_s1_flags;

endmodule
`default_nettype wire

### src/blpw_addr.sv
// output stage: flipped, padded byte address and the result register
`default_nettype none
module blpw_addr #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_pix_valid,
    input  wire logic [COORD_BITS-1:0]        i_pix_x,
    input  wire logic [COORD_BITS-1:0]        i_pix_y,
    input  wire blpw_pkg::t_pix_flags         i_pix_flags,
    input  wire blpw_pkg::t_cfg               i_cfg,
    output logic                              o_ready,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [COORD_BITS-1:0]             o_pixel_x,
    output logic [COORD_BITS-1:0]             o_pixel_y,
    output logic [blpw_pkg::ADDR_W-1:0]       o_byte_address,
    output logic [blpw_pkg::BYTE_W-1:0]       o_pixel_byte,
    output logic                              o_write_alpha,
    output logic                              o_last,
    output logic                              o_error
);

    localparam int AW = blpw_pkg::ADDR_W;

    logic                         r_valid;
    logic [COORD_BITS-1:0]        r_x, r_y;
    logic [AW-1:0]                r_addr;
    logic [blpw_pkg::BYTE_W-1:0]  r_byte;
    logic                         r_alpha, r_last, r_error;

    logic [blpw_pkg::ROW_W-1:0]   width_bytes, row_size;
    logic [AW-1:0]                flipped, x_ext, x_bytes, addr;

    // bytes per pixel is 3 or 4, rows rounded up to a multiple of four
    assign width_bytes = i_cfg.mode ? (blpw_pkg::ROW_W'(i_cfg.width) << 2)
                                    : (blpw_pkg::ROW_W'(i_cfg.width) +
                                       (blpw_pkg::ROW_W'(i_cfg.width) << 1));
    assign row_size    = (width_bytes + blpw_pkg::ROW_ROUND) & blpw_pkg::ROW_MASK;

    // bottom-up buffer, arithmetic wraps modulo the address width
    assign flipped = AW'(i_cfg.height) - AW'(1) - AW'(i_pix_y);
    assign x_ext   = AW'(i_pix_x);
    assign x_bytes = i_cfg.mode ? (x_ext << 2) : (x_ext + (x_ext << 1));
    assign addr    = AW'(flipped * AW'(row_size)) + x_bytes;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_pix_valid) begin
            if (i_pix_flags.error) begin
                r_x     <= '0;
                r_y     <= '0;
                r_addr  <= '0;
                r_byte  <= '0;
                r_alpha <= 1'b0;
                r_last  <= 1'b0;
                r_error <= 1'b1;
            end else begin
                r_x     <= i_pix_x;
                r_y     <= i_pix_y;
                r_addr  <= addr;
                r_byte  <= i_pix_flags.color ? blpw_pkg::FULL_BYTE : '0;
                r_alpha <= i_cfg.mode;
                r_last  <= i_pix_flags.last;
                r_error <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_byte_address = r_addr;
    assign o_pixel_byte   = r_byte;
    assign o_write_alpha  = r_alpha;
    assign o_last         = r_last;
    assign o_error        = r_error;

endmodule
`default_nettype wire

### src/bresenham_line_pixel_writer_core.sv
// top level of the bresenham line pixel writer
`default_nettype none
// Bresenham line rasterizer for a bottom-up, row-padded frame buffer. A start
// transaction (opcode 0) checks both endpoints against the configured image size
// and answers with either an error result or the first pixel; each step
// transaction (opcode 1) answers with the next pixel of the line, the endpoint
// flagged as last. A step while no line runs gives no result. One transaction is
// accepted every cycle while o_stall is low; a result is registered first in the
// walk pixel stage and then in the address stage, whose single 26 by 16 bit
// multiply of the flipped row by the row size sets the cycle time. The user must
// write image size and pixel mode through the configuration port while the block
// is idle; the block itself does not enforce this. Writes take effect at once.
module bresenham_line_pixel_writer_core #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [blpw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [blpw_pkg::DIM_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_opcode,
    input  wire logic [COORD_BITS-1:0]          i_start_x,
    input  wire logic [COORD_BITS-1:0]          i_start_y,
    input  wire logic [COORD_BITS-1:0]          i_end_x,
    input  wire logic [COORD_BITS-1:0]          i_end_y,
    input  wire logic                           i_color,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [COORD_BITS-1:0]               o_pixel_x,
    output logic [COORD_BITS-1:0]               o_pixel_y,
    output logic [blpw_pkg::ADDR_W-1:0]         o_byte_address,
    output logic [blpw_pkg::BYTE_W-1:0]         o_pixel_byte,
    output logic                                o_write_alpha,
    output logic                                o_last,
    output logic                                o_error
);

    blpw_pkg::t_cfg        cfg;
    blpw_pkg::t_pix_flags  pix_flags;
    logic                  pix_valid, addr_ready;
    logic [COORD_BITS-1:0] pix_x, pix_y;

    blpw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    blpw_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_color     (i_color),
        .i_cfg       (cfg),
        .i_ready     (addr_ready),
        .o_pix_valid (pix_valid),
        .o_pix_x     (pix_x),
        .o_pix_y     (pix_y),
        .o_pix_flags (pix_flags)
    );

    blpw_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix_valid    (pix_valid),
        .i_pix_x        (pix_x),
        .i_pix_y        (pix_y),
        .i_pix_flags    (pix_flags),
        .i_cfg          (cfg),
        .o_ready        (addr_ready),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_pixel_byte   (o_pixel_byte),
        .o_write_alpha  (o_write_alpha),
        .o_last         (o_last),
        .o_error        (o_error)
    );

endmodule
`default_nettype wire

### tb/bresenham_line_pixel_writer_core_tb.sv
// testbench for the bresenham line pixel writer: predicts each pixel and checks it against the core
`timescale 1ns / 1ps

module bresenham_line_pixel_writer_core_tb;

    localparam int CW           = 12;
    localparam int LINE_ITEMS   = 900;
    localparam int PIPE_SETTLE  = 4;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic          color;
    } t_cmd;

    typedef struct packed {
        logic [CW-1:0]               x;
        logic [CW-1:0]               y;
        logic [blpw_pkg::ADDR_W-1:0] addr;
        logic [blpw_pkg::BYTE_W-1:0] shade;
        logic                        alpha;
        logic                        last;
        logic                        rejected;
    } t_pixel;

    // line walk predictor and the pixels it still owes
    class pixel_walk_book;
        t_pixel                     pixels_due[$];
        int                         mismatches;
        int                         issued;
        logic [blpw_pkg::DIM_W-1:0] img_w;
        logic [blpw_pkg::DIM_W-1:0] img_h;
        logic                       mode;
        logic [CW-1:0]              cur_x, cur_y, dst_x, dst_y;
        int                         dx, dy_neg, err_acc;
        logic                       x_back, y_back, running, ink;

        function new();
            img_w   = 1;
            img_h   = 1;
            mode    = 1'b0;
            cur_x   = '0;
            cur_y   = '0;
            dst_x   = '0;
            dst_y   = '0;
            dx      = 0;
            dy_neg  = 0;
            err_acc = 0;
            x_back  = 1'b0;
            y_back  = 1'b0;
            running = 1'b0;
            ink     = 1'b0;
        endfunction

        function void write_reg(logic [blpw_pkg::CFG_IDX_W-1:0] idx,
                                logic [blpw_pkg::DIM_W-1:0] val);
            case (idx)
                blpw_pkg::CFG_WIDTH:  img_w = val;
                blpw_pkg::CFG_HEIGHT: img_h = val;
                blpw_pkg::CFG_MODE:   mode  = val[0];
                default:              ;
            endcase
        endfunction

        function t_pixel pixel_at(logic done);
            logic [31:0] bpp, row_bytes, row_from_bottom, byte_addr;
            t_pixel      p;
            bpp             = mode ? 32'd4 : 32'd3;
            row_bytes       = (32'(img_w) * bpp + 32'(blpw_pkg::ROW_ROUND)) &
                              ~32'(blpw_pkg::ROW_ROUND);
            // bottom-up buffer, wraps when the point lies at or beyond the image height
            row_from_bottom = 32'(img_h) - 32'd1 - 32'(cur_y);
            byte_addr       = row_from_bottom * row_bytes + 32'(cur_x) * bpp;
            p.x        = cur_x;
            p.y        = cur_y;
            p.addr     = byte_addr[blpw_pkg::ADDR_W-1:0];
            p.shade    = ink ? blpw_pkg::FULL_BYTE : '0;
            p.alpha    = mode;
            p.last     = done;
            p.rejected = 1'b0;
            return p;
        endfunction

        function void take_cmd(t_cmd c);
            t_pixel p;
            int     e2;
            logic   done;
            if (c.op == blpw_pkg::OP_START) begin
                running = 1'b0;
                if (c.sx >= img_w || c.ex >= img_w || c.sy >= img_h || c.ey >= img_h) begin
                    p          = '0;
                    p.rejected = 1'b1;
                    pixels_due.push_back(p);
                    issued++;
                    return;
                end
                cur_x   = c.sx;
                cur_y   = c.sy;
                dst_x   = c.ex;
                dst_y   = c.ey;
                dx      = (c.ex > c.sx) ? int'(c.ex) - int'(c.sx) : int'(c.sx) - int'(c.ex);
                dy_neg  = (c.ey > c.sy) ? int'(c.sy) - int'(c.ey) : int'(c.ey) - int'(c.sy);
                x_back  = !(c.sx < c.ex);
                y_back  = !(c.sy < c.ey);
                err_acc = dx + dy_neg;
                ink     = c.color;
                done    = (c.sx == c.ex) && (c.sy == c.ey);
                running = !done;
                pixels_due.push_back(pixel_at(done));
                issued++;
            end else if (running) begin
                e2 = 2 * err_acc;
                if (e2 >= dy_neg) begin
                    err_acc += dy_neg;
                    cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
                end
                if (e2 <= dx) begin
                    err_acc += dx;
                    cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
                end
                done = (cur_x == dst_x) && (cur_y == dst_y);
                if (done) begin
                    running = 1'b0;
                end
                pixels_due.push_back(pixel_at(done));
                issued++;
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_pixel(t_pixel got);
            t_pixel want;
            if (pixels_due.size() == 0) begin
                $error("pixel with nothing outstanding: x=%0d y=%0d error=%0b",
                       got.x, got.y, got.rejected);
                mismatches++;
                return;
            end
            want = pixels_due.pop_front();
            cmp_field("pixel_x", 32'(want.x), 32'(got.x));
            cmp_field("pixel_y", 32'(want.y), 32'(got.y));
            cmp_field("byte_address", 32'(want.addr), 32'(got.addr));
            cmp_field("pixel_byte", 32'(want.shade), 32'(got.shade));
            cmp_field("write_alpha", 32'(want.alpha), 32'(got.alpha));
            cmp_field("last", 32'(want.last), 32'(got.last));
            cmp_field("error", 32'(want.rejected), 32'(got.rejected));
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [blpw_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [blpw_pkg::DIM_W-1:0]     i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_opcode;
    logic [CW-1:0]                  i_start_x, i_start_y, i_end_x, i_end_y;
    logic                           i_color;
    logic                           o_valid;
    logic                           i_stall;
    logic [CW-1:0]                  o_pixel_x, o_pixel_y;
    logic [blpw_pkg::ADDR_W-1:0]    o_byte_address;
    logic [blpw_pkg::BYTE_W-1:0]    o_pixel_byte;
    logic                           o_write_alpha, o_last, o_error;

    pixel_walk_book book;
    bit             no_gaps;

    bresenham_line_pixel_writer_core #(
        .COORD_BITS (CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_pixel_byte   (o_pixel_byte),
        .o_write_alpha  (o_write_alpha),
        .o_last         (o_last),
        .o_error        (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_cmd start_cmd(int sx, int sy, int ex, int ey, bit color);
        t_cmd c;
        c.op    = blpw_pkg::OP_START;
        c.sx    = CW'(sx);
        c.sy    = CW'(sy);
        c.ex    = CW'(ex);
        c.ey    = CW'(ey);
        c.color = color;
        return c;
    endfunction

    // endpoint fields are ignored on a step, so they carry noise
    function automatic t_cmd step_cmd();
        t_cmd c;
        c.op    = blpw_pkg::OP_STEP;
        c.sx    = CW'($urandom);
        c.sy    = CW'($urandom);
        c.ex    = CW'($urandom);
        c.ey    = CW'($urandom);
        c.color = 1'($urandom);
        return c;
    endfunction

    function automatic int near(int c, int lim);
        int v;
        if ($urandom_range(0, 7) == 0) begin
            v = $urandom_range(0, lim - 1);
        end else begin
            v = c + int'($urandom_range(0, 20)) - 10;
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > lim - 1) begin
            v = lim - 1;
        end
        return v;
    endfunction

    function automatic logic [blpw_pkg::DIM_W-1:0] rand_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return blpw_pkg::DIM_W'($urandom_range(4097, 8191));
            2:       return blpw_pkg::DIM_W'(4096);
            3:       return blpw_pkg::DIM_W'(1);
            4, 5:    return blpw_pkg::DIM_W'($urandom_range(100, 4095));
            default: return blpw_pkg::DIM_W'($urandom_range(2, 48));
        endcase
    endfunction

    task automatic send(t_cmd c);
        i_valid   <= 1'b1;
        i_opcode  <= c.op;
        i_start_x <= c.sx;
        i_start_y <= c.sy;
        i_end_x   <= c.ex;
        i_end_y   <= c.ey;
        i_color   <= c.color;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        book.take_cmd(c);
    endtask

    task automatic pause();
        int n;
        if (no_gaps) begin
            return;
        end
        case ($urandom_range(0, 19))
            0:             n = $urandom_range(10, 40);
            1, 2, 3, 4, 5: n = $urandom_range(1, 3);
            default:       n = 0;
        endcase
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // hold off until every owed pixel is back and idle steps have left the pipe
    task automatic drain();
        i_valid <= 1'b0;
        while (book.pixels_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [blpw_pkg::CFG_IDX_W-1:0] idx,
                             logic [blpw_pkg::DIM_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        book.write_reg(idx, val);
    endtask

    task automatic configure(logic [blpw_pkg::DIM_W-1:0] w, logic [blpw_pkg::DIM_W-1:0] h,
                             logic m);
        drain();
        cfg_write(blpw_pkg::CFG_WIDTH, w);
        cfg_write(blpw_pkg::CFG_HEIGHT, h);
        cfg_write(blpw_pkg::CFG_MODE, blpw_pkg::DIM_W'(m));
        i_cfg_we <= 1'b0;
    endtask

    task automatic draw(int sx, int sy, int ex, int ey, bit color, int max_steps);
        int n;
        send(start_cmd(sx, sy, ex, ey, color));
        n = 0;
        while (book.running && n < max_steps) begin
            pause();
            send(step_cmd());
            n++;
        end
    endtask

    // receiver: stall runs of random length, mostly short
    initial begin
        int run;
        i_stall = 1'b0;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
            repeat (run) @(posedge i_clk) i_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            repeat (run) @(posedge i_clk) i_stall <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            book.match_pixel('{o_pixel_x, o_pixel_y, o_byte_address, o_pixel_byte,
                               o_write_alpha, o_last, o_error});
        end
    end

    initial begin
        int phase_start, budget, lim_x, lim_y, sx, sy, ex, ey, n;
        book        = new();
        no_gaps     = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = blpw_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_opcode    = blpw_pkg::OP_START;
        i_start_x   = '0;
        i_start_y   = '0;
        i_end_x     = '0;
        i_end_y     = '0;
        i_color     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset geometry, each quadrant, restarts, edges of the coordinate range
        send(step_cmd());
        send(start_cmd(0, 0, 0, 0, 1));
        send(start_cmd(1, 0, 0, 0, 0));
        configure(20, 15, 1'b0);
        draw(5, 5, 7, 6, 1, 100);
        draw(5, 5, 4, 7, 0, 100);
        draw(5, 5, 3, 4, 1, 100);
        draw(5, 5, 6, 3, 0, 100);
        send(start_cmd(0, 0, 0, 4095, 1));
        draw(19, 14, 0, 0, 1, 1);
        draw(0, 14, 19, 0, 0, 1);
        // geometry changes under a running line
        configure(4096, 4096, 1'b1);
        send(step_cmd());
        send(step_cmd());
        draw(4095, 4095, 4094, 4094, 1, 100);
        send(step_cmd());
        configure(0, 0, 1'b1);
        send(start_cmd(0, 0, 0, 0, 1));

        while (book.issued < LINE_ITEMS) begin
            configure(rand_dim(), rand_dim(), 1'($urandom_range(0, 1)));
            no_gaps     = ($urandom_range(0, 3) == 0);
            budget      = $urandom_range(40, 120);
            phase_start = book.issued;
            while (book.issued - phase_start < budget && book.issued < LINE_ITEMS) begin
                lim_x = (book.img_w > 4096) ? 4096 : int'(book.img_w);
                lim_y = (book.img_h > 4096) ? 4096 : int'(book.img_h);
                case ($urandom_range(0, 19))
                    0: begin
                        send(start_cmd($urandom_range(0, 4095), $urandom_range(0, 4095),
                                       $urandom_range(0, 4095), $urandom_range(0, 4095),
                                       1'($urandom)));
                    end
                    1: begin
                        send(step_cmd());
                    end
                    2: begin
                        if (book.running) begin
                            configure(rand_dim(), rand_dim(), 1'($urandom_range(0, 1)));
                            n = 0;
                            while (book.running && n < 12) begin
                                pause();
                                send(step_cmd());
                                n++;
                            end
                        end
                    end
                    default: begin
                        if (lim_x == 0 || lim_y == 0) begin
                            send(start_cmd($urandom_range(0, 4095), $urandom_range(0, 4095),
                                           $urandom_range(0, 4095), $urandom_range(0, 4095),
                                           1'($urandom)));
                        end else begin
                            sx = $urandom_range(0, lim_x - 1);
                            sy = $urandom_range(0, lim_y - 1);
                            ex = near(sx, lim_x);
                            ey = near(sy, lim_y);
                            // endpoint just past the right edge
                            if ($urandom_range(0, 15) == 0 && book.img_w < 4096) begin
                                ex = int'(book.img_w);
                            end
                            draw(sx, sy, ex, ey, 1'($urandom),
                                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : 200);
                        end
                    end
                endcase
                pause();
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
src/blpw_pkg.sv
src/blpw_cfg.sv
src/blpw_walk.sv
src/blpw_addr.sv
src/bresenham_line_pixel_writer_core.sv
tb/bresenham_line_pixel_writer_core_tb.sv
